>>> sv/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg: shared constants for the bilinear texture sampler
// Register indexes, word codes and default sizes.
// ----------------------------------------------------------------------------
package tsw_pkg;

	// default build sizes
	localparam int DEF_MAX_WIDTH    = 256;
	localparam int DEF_MAX_HEIGHT   = 256;
	localparam int DEF_UV_FRAC_BITS = 16;
	localparam int DEF_WEIGHT_BITS  = 8;

	// fixed field widths
	localparam int ADDR_W   = 16;
	localparam int TEXEL_W  = 32;
	localparam int COORD_W  = 24;
	localparam int DIM_W    = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CALC_W   = 13;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA   = 3'd4;

	// word kinds on the input stream
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// mode codes
	localparam logic WRAP_REPEAT = 1'b0;
	localparam logic WRAP_CLAMP  = 1'b1;
	localparam logic FILT_NEAREST  = 1'b0;
	localparam logic FILT_BILINEAR = 1'b1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

>>> sv/texture_sampler_wrap_bilinear_top.sv
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear_top: RGBA8 texture sampler
// Texel memory filled by write words; sample words return a nearest or
// bilinear filtered texel with repeat or clamp addressing.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tuser op, tdata index,texel,u,v
//  m_*       out  m_tvalid/m_tready    tdata red,green,blue,alpha
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Writes and nearest samples take one memory port access each; a bilinear
//  sample takes four, one per quad texel on the single-port texel memory.
//  The texel memory is not cleared by reset; only control state is.
//  Stalls on the output back up the pipeline register by register.
// ----------------------------------------------------------------------------
module texture_sampler_wrap_bilinear_top
	import tsw_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int UV_FRAC_BITS = DEF_UV_FRAC_BITS,
	parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // texel_index, texel_data, u_coord, v_coord
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // red, green, blue, alpha
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	localparam int F   = UV_FRAC_BITS;
	localparam int WB  = WEIGHT_BITS;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int PUW = COORD_W + WW + 1;
	localparam int PVW = COORD_W + HW + 1;
	localparam int RBW = HW + WW;

	// configuration registers
	logic [DIM_W-1:0] tex_width_q, tex_height_q;
	logic wrap_mode_q, filter_mode_q, has_alpha_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q   <= DIM_W'(1);
			tex_height_q  <= DIM_W'(1);
			wrap_mode_q   <= WRAP_REPEAT;
			filter_mode_q <= FILT_NEAREST;
			has_alpha_q   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEX_WIDTH:   tex_width_q   <= cfg_data;
				REG_TEX_HEIGHT:  tex_height_q  <= cfg_data;
				REG_WRAP_MODE:   wrap_mode_q   <= cfg_data[0];
				REG_FILTER_MODE: filter_mode_q <= cfg_data[0];
				REG_HAS_ALPHA:   has_alpha_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective size: zero reads as one, saturate at the build maximum
	logic [CALC_W-1:0] w_calc, h_calc;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic bil;

	always_comb begin
		if (tex_width_q == '0)
			w_calc = CALC_W'(1);
		else if (CALC_W'(tex_width_q) > CALC_W'(MAX_WIDTH))
			w_calc = CALC_W'(MAX_WIDTH);
		else
			w_calc = CALC_W'(tex_width_q);
		if (tex_height_q == '0)
			h_calc = CALC_W'(1);
		else if (CALC_W'(tex_height_q) > CALC_W'(MAX_HEIGHT))
			h_calc = CALC_W'(MAX_HEIGHT);
		else
			h_calc = CALC_W'(tex_height_q);
		w_eff = w_calc[WW-1:0];
		h_eff = h_calc[HW-1:0];
		bil   = (filter_mode_q == FILT_BILINEAR);
	end

	// ready chain, back to front
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;
	logic f_done;

	assign rdy_s7 = !vld_s7 || m_tready;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || f_done;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// stage 1: input register
	logic op_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [TEXEL_W-1:0] dat_s1;
	logic signed [COORD_W-1:0] uc_s1, vc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (rdy_s1) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			op_s1  <= s_tuser;
			idx_s1 <= s_tdata[15:0];
			dat_s1 <= s_tdata[47:16];
			uc_s1  <= s_tdata[71:48];
			vc_s1  <= s_tdata[95:72];
		end
	end

	// stage 2: scale by texture size
	logic op_s2;
	logic [ADDR_W-1:0] idx_s2;
	logic [TEXEL_W-1:0] dat_s2;
	logic signed [PUW-1:0] pu_s2;
	logic signed [PVW-1:0] pv_s2;
	logic [F+WW-1:0] tu_s2;
	logic [F+HW-1:0] tv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (rdy_s2) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			dat_s2 <= dat_s1;
			pu_s2  <= PUW'(uc_s1) * $signed({1'b0, w_eff});
			pv_s2  <= PVW'(vc_s1) * $signed({1'b0, h_eff});
			tu_s2  <= (F+WW)'(uc_s1[F-1:0]) * (F+WW)'(w_eff);
			tv_s2  <= (F+HW)'(vc_s1[F-1:0]) * (F+HW)'(h_eff);
		end
	end

	// stage 3: texel coordinates, wrap or clamp, weights
	logic signed [PUW-1:0] pun, x0, x1, wxs;
	logic signed [PVW-1:0] pvn, y0, y1, hys;
	logic [F+WW:0] tun;
	logic [F+HW:0] tvn;
	logic [WW:0] qu, mu0p;
	logic [HW:0] qv, mv0p;
	logic [WW-1:0] mu0, mu1, cu0, cu1, nx0, nx1;
	logic [HW-1:0] mv0, mv1, cv0, cv1, ny0, ny1;
	logic [F+WB-1:0] fru, frv;
	logic [WB-1:0] nfu, nfv;

	always_comb begin
		pun = pu_s2 + (bil ? PUW'(0) : (PUW'(1) <<< (F - 1)));
		pvn = pv_s2 + (bil ? PVW'(0) : (PVW'(1) <<< (F - 1)));
		x0  = pun >>> F;
		y0  = pvn >>> F;
		x1  = x0 + PUW'(1);
		y1  = y0 + PVW'(1);
		// repeat: the floor of frac(u)*W (+half) is the wrapped column
		tun = (F+WW+1)'(tu_s2) + (bil ? (F+WW+1)'(0) : ((F+WW+1)'(1) << (F - 1)));
		tvn = (F+HW+1)'(tv_s2) + (bil ? (F+HW+1)'(0) : ((F+HW+1)'(1) << (F - 1)));
		qu  = tun[F+WW:F];
		qv  = tvn[F+HW:F];
		mu0 = (qu == {1'b0, w_eff}) ? '0 : qu[WW-1:0];
		mv0 = (qv == {1'b0, h_eff}) ? '0 : qv[HW-1:0];
		mu0p = {1'b0, mu0} + (WW+1)'(1);
		mv0p = {1'b0, mv0} + (HW+1)'(1);
		mu1 = (mu0p == {1'b0, w_eff}) ? '0 : mu0p[WW-1:0];
		mv1 = (mv0p == {1'b0, h_eff}) ? '0 : mv0p[HW-1:0];
		// clamp to edge
		wxs = $signed({{(PUW-WW){1'b0}}, w_eff});
		hys = $signed({{(PVW-HW){1'b0}}, h_eff});
		cu0 = (x0 < 0) ? '0 : (x0 >= wxs) ? (w_eff - WW'(1)) : x0[WW-1:0];
		cu1 = (x1 < 0) ? '0 : (x1 >= wxs) ? (w_eff - WW'(1)) : x1[WW-1:0];
		cv0 = (y0 < 0) ? '0 : (y0 >= hys) ? (h_eff - HW'(1)) : y0[HW-1:0];
		cv1 = (y1 < 0) ? '0 : (y1 >= hys) ? (h_eff - HW'(1)) : y1[HW-1:0];
		nx0 = (wrap_mode_q == WRAP_CLAMP) ? cu0 : mu0;
		nx1 = (wrap_mode_q == WRAP_CLAMP) ? cu1 : mu1;
		ny0 = (wrap_mode_q == WRAP_CLAMP) ? cv0 : mv0;
		ny1 = (wrap_mode_q == WRAP_CLAMP) ? cv1 : mv1;
		// weight: fraction bits scaled to the weight width
		fru = {pu_s2[F-1:0], {WB{1'b0}}};
		frv = {pv_s2[F-1:0], {WB{1'b0}}};
		nfu = bil ? fru[F+WB-1:F] : '0;
		nfv = bil ? frv[F+WB-1:F] : '0;
	end

	logic op_s3, bil_s3;
	logic [ADDR_W-1:0] idx_s3;
	logic [TEXEL_W-1:0] dat_s3;
	logic [WW-1:0] cx0_s3, cx1_s3;
	logic [HW-1:0] cy0_s3, cy1_s3;
	logic [WB-1:0] fu_s3, fv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (rdy_s3) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			op_s3  <= op_s2;
			bil_s3 <= bil;
			idx_s3 <= idx_s2;
			dat_s3 <= dat_s2;
			cx0_s3 <= nx0;
			cx1_s3 <= nx1;
			cy0_s3 <= ny0;
			cy1_s3 <= ny1;
			fu_s3  <= nfu;
			fv_s3  <= nfv;
		end
	end

	// stage 4: row base addresses
	logic op_s4, bil_s4;
	logic [ADDR_W-1:0] idx_s4;
	logic [TEXEL_W-1:0] dat_s4;
	logic [WW-1:0] cx0_s4, cx1_s4;
	logic [RBW-1:0] rb0_s4, rb1_s4;
	logic [WB-1:0] fu_s4, fv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (rdy_s4) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			op_s4  <= op_s3;
			bil_s4 <= bil_s3;
			idx_s4 <= idx_s3;
			dat_s4 <= dat_s3;
			cx0_s4 <= cx0_s3;
			cx1_s4 <= cx1_s3;
			rb0_s4 <= RBW'(cy0_s3) * RBW'(w_eff);
			rb1_s4 <= RBW'(cy1_s3) * RBW'(w_eff);
			fu_s4  <= fu_s3;
			fv_s4  <= fv_s3;
		end
	end

	// memory port sequencer: one access per cycle, quad order 00,10,01,11
	// a read waits while the returned last texel cannot move on to stage 5
	logic [1:0] cnt_q;
	logic f_last, f_issue, mem_we;
	logic [ADDR_W-1:0] rd_addr;
	logic rd_v_q, rd_last_q, rdy_rd;

	assign rdy_rd = !(rd_v_q && rd_last_q) || rdy_s5;

	always_comb begin
		f_last  = bil_s4 ? (cnt_q == 2'd3) : 1'b1;
		f_issue = vld_s4 && (op_s4 == OP_SAMPLE) && rdy_rd;
		mem_we  = vld_s4 && (op_s4 == OP_WRITE);
		f_done  = mem_we || (f_issue && f_last);
		rd_addr = ADDR_W'(32'(cnt_q[1] ? rb1_s4 : rb0_s4) + 32'(cnt_q[0] ? cx1_s4 : cx0_s4));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 2'd0;
		else if (f_done) cnt_q <= 2'd0;
		else if (f_issue) cnt_q <= cnt_q + 2'd1;
	end

	// texel memory, registered read
	logic [TEXEL_W-1:0] mem [0:(1<<ADDR_W)-1];
	logic [TEXEL_W-1:0] mem_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[idx_s4] <= dat_s4;
		else if (f_issue)
			mem_q <= mem[rd_addr];
	end

	// read return tracking; a last texel holds here until stage 5 takes it
	logic rd_bil_q;
	logic [1:0] rd_slot_q;
	logic [WB-1:0] rd_fu_q, rd_fv_q;
	logic [TEXEL_W-1:0] acc_q [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_v_q <= 1'b0;
		else rd_v_q <= f_issue || (rd_v_q && rd_last_q && !rdy_s5);
	end

	always_ff @(posedge clk) begin
		if (f_issue) begin
			rd_last_q <= f_last;
			rd_slot_q <= cnt_q;
			rd_bil_q  <= bil_s4;
			rd_fu_q   <= fu_s4;
			rd_fv_q   <= fv_s4;
		end
		if (rd_v_q && !rd_last_q && rd_slot_q != 2'd3)
			acc_q[rd_slot_q] <= mem_q;
	end

	// stage 5: assembled quad
	logic [TEXEL_W-1:0] q_s5 [0:3];
	logic [WB-1:0] fu_s5, fv_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (rd_v_q && rd_last_q && rdy_s5) vld_s5 <= 1'b1;
		else if (rdy_s6) vld_s5 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rd_v_q && rd_last_q && rdy_s5) begin
			q_s5[0] <= rd_bil_q ? acc_q[0] : mem_q;
			q_s5[1] <= rd_bil_q ? acc_q[1] : mem_q;
			q_s5[2] <= rd_bil_q ? acc_q[2] : mem_q;
			q_s5[3] <= mem_q;
			fu_s5   <= rd_fu_q;
			fv_s5   <= rd_fv_q;
		end
	end

	// (a*(1-f) + b*f) >> WB, truncated to 8 bits
	function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
			input logic [WB-1:0] f);
		logic [WB:0] one_m;
		logic [WB+9:0] acc;
		one_m = {1'b1, {WB{1'b0}}} - (WB+1)'(f);
		acc = (WB+10)'(a) * (WB+10)'(one_m) + (WB+10)'(b) * (WB+10)'(f);
		return acc[WB+7:WB];
	endfunction

	// stage 6: horizontal blend of both rows
	logic [7:0] top_s6 [0:3];
	logic [7:0] bot_s6 [0:3];
	logic [WB-1:0] fv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (rdy_s6) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) begin
			for (int ch = 0; ch < 4; ch++) begin
				top_s6[ch] <= blend8(q_s5[0][8*ch +: 8], q_s5[1][8*ch +: 8], fu_s5);
				bot_s6[ch] <= blend8(q_s5[2][8*ch +: 8], q_s5[3][8*ch +: 8], fu_s5);
			end
			fv_s6 <= fv_s5;
		end
	end

	// stage 7: vertical blend into the output register
	logic [31:0] out_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (rdy_s7) vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && vld_s6) begin
			for (int ch = 0; ch < 3; ch++)
				out_s7[8*ch +: 8] <= blend8(top_s6[ch], bot_s6[ch], fv_s6);
			out_s7[31:24] <= has_alpha_q ? blend8(top_s6[3], bot_s6[3], fv_s6) : ALPHA_OPAQUE;
		end
	end

	assign m_tvalid = vld_s7;
	assign m_tdata  = out_s7;

endmodule
